// ===== hw/rtl/coed_pkg.sv =====
// Shared types, widths and filter coefficients for the curve onset edge detector.
package coed_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int TAP_COUNT      = 7;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int STEP_W   = 16;
   localparam int INDEX_W  = 13;
   localparam int TIME_W   = 28;
   localparam int PROD_W   = 33;
   localparam int SMOOTH_W = 35;
   localparam int GRAD_W   = 36;
   localparam int SCAN_W   = 39;

   typedef logic [COEF_W-1:0] coef_array_type [TAP_COUNT];

   localparam coef_array_type COEFS = '{
      16'd393, 16'd3998, 16'd15860, 16'd25100, 16'd15860, 16'd3998, 16'd393
   };

   typedef struct packed {
      logic accept;
      logic drain;
      logic read;
      logic test;
      logic load_out;
      logic clear;
   } coed_cmd_type;

   typedef struct packed {
      logic few_samples;
      logic hit;
      logic scan_end;
   } coed_status_type;

endpackage

// ===== hw/rtl/curve_onset_edge_detector.sv =====
// Top level of the curve onset edge detector: controller plus datapath.
// Samples of a curve are taken one per cycle while req_stall is low (controller in LOAD);
// once the last sample is in, the scan reads the stored gradients one at a time from the
// gradient store, each in a READ state followed by a TEST state.
// A new curve is taken while the previous result still waits on the output register.
// Synchronous active-high reset clears the controller, sample count and history and sets
// time_step to 1; the gradient store is not cleared.
module curve_onset_edge_detector
   import coed_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [INDEX_W-1:0]         rsp_onset_index,
   output logic [TIME_W-1:0]          rsp_onset_time,
   input  logic                       csr_wr_en,
   input  logic [STEP_W-1:0]          csr_wr_data
);

   coed_cmd_type    cmd;
   coed_status_type status;

   coed_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .status          (status)
   );

   coed_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_onset_index (rsp_onset_index),
      .rsp_onset_time  (rsp_onset_time)
   );

endmodule

// ===== hw/rtl/coed_dp.sv =====
// Datapath: smoothing filter lanes, gradient store, maximum tracking, scan and scaling.
module coed_dp
   import coed_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  coed_cmd_type               cmd,
   output coed_status_type            status,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       csr_wr_en,
   input  logic [STEP_W-1:0]          csr_wr_data,
   output logic [INDEX_W-1:0]         rsp_onset_index,
   output logic [TIME_W-1:0]          rsp_onset_time
);

   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int AW    = $clog2(MAX_POINTS);
   localparam int MUL_W = CW + STEP_W;

   logic signed [SAMPLE_W-1:0] hist_ff [TAP_COUNT-1];
   logic signed [SAMPLE_W-1:0] tap    [TAP_COUNT];
   logic signed [PROD_W-1:0]   prod_ff [TAP_COUNT];
   logic signed [PROD_W-1:0]   prod_in [TAP_COUNT];
   logic [CW-1:0]              count_ff;
   logic                       valid1_ff;
   logic                       first1_ff;
   logic [AW-1:0]              waddr1_ff;
   logic signed [SMOOTH_W-1:0] prev_ff;
   logic signed [SMOOTH_W-1:0] smooth;
   logic signed [GRAD_W-1:0]   grad;
   logic signed [GRAD_W-1:0]   max_ff;
   logic signed [GRAD_W-1:0]   mem [MAX_POINTS];
   logic signed [GRAD_W-1:0]   rd_data_ff;
   logic signed [SCAN_W-1:0]   five_g;
   logic [AW-1:0]              addr_ff;
   logic [CW-1:0]              idx_ff;
   logic [CW-1:0]              idx_plus;
   logic [STEP_W-1:0]          time_step_ff;
   logic                       store_en;

   assign store_en = cmd.accept && (count_ff < CW'(MAX_POINTS));

   always_comb begin
      tap[0] = req_sample;
      for (int k = 1; k < TAP_COUNT; k++) begin
         tap[k] = hist_ff[k-1];
      end
      for (int k = 0; k < TAP_COUNT; k++) begin
         prod_in[k] = $signed(PROD_W'(COEFS[k])) * PROD_W'(tap[k]);
      end
   end

   always_comb begin
      smooth = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         smooth = smooth + SMOOTH_W'(prod_ff[k]);
      end
      grad = GRAD_W'(smooth) - GRAD_W'(prev_ff);
   end

   assign five_g   = (SCAN_W'(rd_data_ff) <<< 2) + SCAN_W'(rd_data_ff);
   assign idx_plus = CW'(addr_ff) + CW'(1);

   assign status.few_samples = count_ff < CW'(2);
   assign status.hit         = five_g > SCAN_W'(max_ff);
   assign status.scan_end    = idx_plus == (count_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         valid1_ff    <= 1'b0;
         time_step_ff <= STEP_W'(1);
         for (int k = 0; k < TAP_COUNT - 1; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            time_step_ff <= csr_wr_data;
         end
         valid1_ff <= store_en;
         if (cmd.clear) begin
            count_ff <= '0;
            for (int k = 0; k < TAP_COUNT - 1; k++) begin
               hist_ff[k] <= '0;
            end
         end else if (store_en) begin
            count_ff   <= count_ff + CW'(1);
            hist_ff[0] <= req_sample;
            for (int k = 1; k < TAP_COUNT - 1; k++) begin
               hist_ff[k] <= hist_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         prod_ff   <= prod_in;
         first1_ff <= count_ff == '0;
         waddr1_ff <= AW'(count_ff - CW'(1));
      end
      if (valid1_ff) begin
         prev_ff <= smooth;
         if (!first1_ff) begin
            if (waddr1_ff == '0 || grad > max_ff) begin
               max_ff <= grad;
            end
         end
      end
      if (cmd.drain) begin
         idx_ff  <= count_ff;
         addr_ff <= '0;
      end else if (cmd.test) begin
         if (status.hit) begin
            idx_ff <= idx_plus;
         end else begin
            addr_ff <= addr_ff + AW'(1);
         end
      end
      if (cmd.load_out) begin
         rsp_onset_index <= INDEX_W'(idx_ff);
         rsp_onset_time  <= TIME_W'(MUL_W'(idx_ff) * MUL_W'(time_step_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (valid1_ff && !first1_ff) begin
         mem[waddr1_ff] <= grad;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

endmodule

// ===== hw/rtl/coed_ctrl.sv =====
// Controller: sample loading, gradient scan sequencing and result handshake.
module coed_ctrl
   import coed_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_last_sample,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output coed_cmd_type    cmd,
   input  coed_status_type status
);

   typedef enum logic [2:0] {
      LOAD,
      DRAIN,
      READ,
      TEST,
      FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_stall = state_ff != LOAD;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.accept   = (state_ff == LOAD) && req_valid;
      cmd.drain    = state_ff == DRAIN;
      cmd.read     = state_ff == READ;
      cmd.test     = state_ff == TEST;
      cmd.load_out = (state_ff == FINISH) && (!rsp_valid_ff || !rsp_stall);
      cmd.clear    = cmd.load_out;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end

      unique case (state_ff)
         LOAD: begin
            if (cmd.accept && req_last_sample) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = status.few_samples ? FINISH : READ;
         end
         READ: begin
            state_in = TEST;
         end
         TEST: begin
            state_in = (status.hit || status.scan_end) ? FINISH : READ;
         end
         FINISH: begin
            if (cmd.load_out) begin
               state_in = LOAD;
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
